>>> rtl/core/sls_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sls_pkg
// Shared types and constants of the lateral steering block.
// ---------------------------------------------------------------------------
package sls_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int STEPS      = 16;

	localparam logic signed [47:0] PI_Q16      = 48'sd205887;
	localparam logic signed [47:0] TWO_PI_Q16  = 48'sd411775;
	localparam logic signed [47:0] HALF_PI_Q16 = 48'sd102944;

	localparam logic [1:0] REG_GAIN  = 2'd0;
	localparam logic [1:0] REG_SPEED = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	function automatic logic signed [47:0] atan_entry(input logic [3:0] i);
		logic signed [47:0] r;
		case (i)
			4'd0:    r = 48'sd51472;
			4'd1:    r = 48'sd30386;
			4'd2:    r = 48'sd16055;
			4'd3:    r = 48'sd8150;
			4'd4:    r = 48'sd4091;
			4'd5:    r = 48'sd2047;
			4'd6:    r = 48'sd1024;
			4'd7:    r = 48'sd512;
			4'd8:    r = 48'sd256;
			4'd9:    r = 48'sd128;
			4'd10:   r = 48'sd64;
			4'd11:   r = 48'sd32;
			4'd12:   r = 48'sd16;
			4'd13:   r = 48'sd8;
			4'd14:   r = 48'sd4;
			default: r = 48'sd2;
		endcase
		return r;
	endfunction

	// Controller commands to the datapath.
	typedef struct packed {
		logic load_wr;
		logic q_start;
		logic scan_rd;
		logic scan_cmp;
		logic pick_rd;
		logic pick_set;
		logic sqrt_step;
		logic rot_init;
		logic rot_step;
		logic at_init;
		logic norm_step;
		logic at_step;
		logic fin;
		logic res_set;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic sqrt_done;
		logic step_done;
		logic norm_done;
		logic at_zero;
	} stat_t;

endpackage
`default_nettype wire

>>> rtl/core/sls_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sls_ctrl
// Sequencer: scan, square root, sign rotation, atan2 and final sum.
// ---------------------------------------------------------------------------
module sls_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_fire,
	input  wire                 in_query,
	input  wire                 out_busy,
	input  sls_pkg::stat_t      stat,
	output logic                idle,
	output sls_pkg::cmd_t       cmd
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SCAN = 10'b0000000010,
		S_LAST = 10'b0000000100,
		S_PRD  = 10'b0000001000,
		S_SQRT = 10'b0000010000,
		S_ROT  = 10'b0000100000,
		S_NORM = 10'b0001000000,
		S_AT   = 10'b0010000000,
		S_FIN  = 10'b0100000000,
		S_OUT  = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		idle    = 1'b0;
		case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (in_fire) begin
					if (in_query) begin
						cmd.q_start = 1'b1;
						cmd.scan_rd = 1'b1;
						state_d     = S_SCAN;
					end else begin
						cmd.load_wr = 1'b1;
					end
				end
			end
			S_SCAN: begin
				// Data read last cycle is compared while the next entry is read.
				cmd.scan_cmp = 1'b1;
				if (stat.scan_last) begin
					state_d = S_LAST;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_LAST: begin
				cmd.pick_rd = 1'b1;
				state_d     = S_PRD;
			end
			S_PRD: begin
				cmd.pick_set = 1'b1;
				state_d      = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (stat.sqrt_done) begin
					state_d      = S_ROT;
					cmd.rot_init = 1'b1;
				end
			end
			S_ROT: begin
				cmd.rot_step = 1'b1;
				if (stat.step_done) begin
					state_d     = S_NORM;
					cmd.at_init = 1'b1;
				end
			end
			S_NORM: begin
				if (stat.at_zero) begin
					state_d = S_FIN;
				end else if (stat.norm_done) begin
					state_d = S_AT;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			S_AT: begin
				cmd.at_step = 1'b1;
				if (stat.step_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_busy) begin
					cmd.res_set = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_onecmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rot_step && cmd.at_step))
		else $error("rotation and atan2 steps overlap");
	a_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_set |-> $past(state_q == S_OUT || state_q == S_FIN))
		else $error("result without final sum");
	a_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> state_q == S_OUT)
		else $error("final sum not followed by output");

endmodule
`default_nettype wire

>>> rtl/core/sls_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sls_dp
// Path table, nearest point search, square root and CORDIC datapath.
// ---------------------------------------------------------------------------
module sls_dp (
	input  wire                   clk,
	input  wire                   arst_n,
	input  sls_pkg::cmd_t         cmd,
	output sls_pkg::stat_t        stat,
	input  wire [5:0]             point_index,
	input  wire signed [15:0]     pos_x,
	input  wire signed [15:0]     pos_y,
	input  wire signed [15:0]     angle,
	input  wire [15:0]            gain,
	input  wire signed [15:0]     speed,
	input  wire [6:0]             count,
	output logic signed [15:0]    steer_angle,
	output logic [5:0]            nearest_index,
	output logic signed [15:0]    cte,
	output logic signed [15:0]    head_err
);

	localparam int IW = sls_pkg::IDX_W;
	localparam int CW = sls_pkg::CNT_W;

	logic [15:0] mem_x [sls_pkg::MAX_POINTS];
	logic [15:0] mem_y [sls_pkg::MAX_POINTS];
	logic [15:0] mem_h [sls_pkg::MAX_POINTS];
	logic [15:0] rd_x_q, rd_y_q, rd_h_q;
	logic [IW-1:0] rd_addr;

	logic signed [15:0] px_q, py_q, yaw_q;
	logic [CW-1:0] n_q, ptr_q, cmp_idx_q;
	logic [IW-1:0] best_q;
	logic [32:0] best_d2_q;
	logic first_q;

	// Clamp the number of searched entries to one .. MAX_POINTS.
	logic [CW-1:0] n_clamp;
	always_comb begin
		if (count == 7'd0) begin
			n_clamp = CW'(1);
		end else if ({{(32-7){1'b0}}, count} > 32'(sls_pkg::MAX_POINTS)) begin
			n_clamp = CW'(sls_pkg::MAX_POINTS);
		end else begin
			n_clamp = CW'(count);
		end
	end

	// The scan reads entry zero in the cycle the query is accepted.
	assign rd_addr = cmd.pick_rd ? best_q : (cmd.q_start ? '0 : ptr_q[IW-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.load_wr && ({{(32-6){1'b0}}, point_index} < 32'(sls_pkg::MAX_POINTS))) begin
			mem_x[IW'(point_index)] <= pos_x;
			mem_y[IW'(point_index)] <= pos_y;
			mem_h[IW'(point_index)] <= angle;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
		rd_h_q <= mem_h[rd_addr];
	end

	// Squared distance of the entry read last cycle.
	logic signed [16:0] ddx, ddy;
	logic [32:0] d2;
	assign ddx = 17'(px_q) - 17'(signed'(rd_x_q));
	assign ddy = 17'(py_q) - 17'(signed'(rd_y_q));
	assign d2  = 33'(34'(ddx * ddx) + 34'(ddy * ddy));

	// Square root state.
	logic [33:0] sq_v_q, sq_res_q, sq_bit_q;
	logic signed [16:0] dx_q, dy_q, hd_q;
	logic [15:0] e_mag_q;
	logic [4:0] step_q;
	logic signed [47:0] cx_q, cy_q, cz_q;
	logic e_neg_q;
	logic signed [16:0] e_q;
	logic signed [16:0] theta_q;

	// CORDIC step shared by rotation and vectoring.
	logic signed [47:0] xs, ys, tab;
	logic dir;
	logic rot_pos;
	logic e_sign;
	assign xs  = cx_q >>> step_q[3:0];
	assign ys  = cy_q >>> step_q[3:0];
	assign tab = sls_pkg::atan_entry(step_q[3:0]);
	assign dir = cmd.rot_step ? (cz_q >= 0) : !(cy_q > 0);
	// Rotated y after the current step, used for the sign after the last step.
	assign rot_pos = (dir ? cy_q + xs : cy_q - xs) > 0;
	assign e_sign  = cmd.at_init ? rot_pos : e_neg_q;

	// Heading reduction to [-pi, pi] then quadrant fold.
	logic signed [47:0] z0, zr, xr, yr, zf;
	always_comb begin
		z0 = -(48'(hd_q) <<< 5);
		zr = z0;
		for (int k = 0; k < 3; k++) begin
			if (zr > sls_pkg::PI_Q16) begin
				zr = zr - sls_pkg::TWO_PI_Q16;
			end else if (zr < -sls_pkg::PI_Q16) begin
				zr = zr + sls_pkg::TWO_PI_Q16;
			end
		end
		xr = 48'(dx_q) <<< 16;
		yr = 48'(dy_q) <<< 16;
		zf = zr;
		if (zr > sls_pkg::HALF_PI_Q16) begin
			xr = -xr; yr = -yr; zf = zr - sls_pkg::PI_Q16;
		end else if (zr < -sls_pkg::HALF_PI_Q16) begin
			xr = -xr; yr = -yr; zf = zr + sls_pkg::PI_Q16;
		end
	end

	// atan2 start values.
	logic signed [16:0] e_s;
	logic signed [47:0] ay, ax, az, absy, mx;
	always_comb begin
		e_s = e_sign ? -17'(e_mag_q) : 17'(e_mag_q);
		ay  = 48'($signed({1'b0, gain})) * 48'(e_s);
		ax  = 48'(speed) <<< 8;
		az  = '0;
		if (ax < 0) begin
			az = (ay >= 0) ? sls_pkg::PI_Q16 : -sls_pkg::PI_Q16;
			ax = -ax;
			ay = -ay;
		end
		absy = (cy_q < 0) ? -cy_q : cy_q;
		mx   = (cx_q > absy) ? cx_q : absy;
	end

	always_comb begin
		stat.scan_last = (cmp_idx_q + CW'(1)) == n_q;
		stat.sqrt_done = (sq_bit_q == 34'd0);
		stat.step_done = (step_q == 5'd15);
		stat.norm_done = mx >= (48'sd1 <<< 40);
		stat.at_zero   = (cx_q == 0) && (cy_q == 0);
	end

	logic signed [47:0] dsum, dw, rnd;
	always_comb begin
		dsum = (stat.at_zero ? 48'sd0 : cz_q) + (48'(theta_q) <<< 5);
		dw   = dsum;
		if (dsum > sls_pkg::PI_Q16) begin
			dw = dsum - sls_pkg::TWO_PI_Q16;
		end else if (dsum < -sls_pkg::PI_Q16) begin
			dw = dsum + sls_pkg::TWO_PI_Q16;
		end
		rnd = (dw + 48'sd16) >>> 5;
	end

	always_ff @(posedge clk) begin
		if (cmd.q_start) begin
			px_q      <= pos_x;
			py_q      <= pos_y;
			yaw_q     <= angle;
			n_q       <= n_clamp;
			ptr_q     <= CW'(1);
			cmp_idx_q <= '0;
			first_q   <= 1'b1;
		end
		if (cmd.scan_rd && !cmd.q_start) begin
			ptr_q <= ptr_q + CW'(1);
		end
		if (cmd.scan_cmp) begin
			cmp_idx_q <= cmp_idx_q + CW'(1);
			first_q   <= 1'b0;
			if (first_q || d2 < best_d2_q) begin
				best_d2_q <= d2;
				best_q    <= cmp_idx_q[IW-1:0];
			end
		end
		if (cmd.pick_set) begin
			dx_q     <= 17'(px_q) - 17'(signed'(rd_x_q));
			dy_q     <= 17'(py_q) - 17'(signed'(rd_y_q));
			hd_q     <= 17'(signed'(rd_h_q));
			theta_q  <= 17'(signed'(rd_h_q)) - 17'(yaw_q);
			sq_v_q   <= 34'(best_d2_q);
			sq_res_q <= '0;
			sq_bit_q <= 34'd1 << 32;
		end
		if (cmd.sqrt_step && sq_bit_q != 34'd0) begin
			if (sq_bit_q > sq_v_q && sq_res_q == 34'd0) begin
				sq_bit_q <= sq_bit_q >> 2;
			end else begin
				if (sq_v_q >= sq_res_q + sq_bit_q) begin
					sq_v_q   <= sq_v_q - (sq_res_q + sq_bit_q);
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
		end
		if (cmd.sqrt_step && stat.sqrt_done) begin
			e_mag_q <= (sq_res_q > 34'd32767) ? 16'd32767 : sq_res_q[15:0];
		end
		if (cmd.at_init) begin
			cx_q   <= ax;
			cy_q   <= ay;
			cz_q   <= az;
			step_q <= '0;
		end else if (cmd.rot_init) begin
			cx_q   <= xr;
			cy_q   <= yr;
			cz_q   <= zf;
			step_q <= '0;
		end else if (cmd.norm_step) begin
			cx_q <= cx_q <<< 1;
			cy_q <= cy_q <<< 1;
		end else if (cmd.rot_step || cmd.at_step) begin
			step_q <= step_q + 5'd1;
			if (cmd.rot_step ? dir : !dir) begin
				// rotate: z>=0 ; vectoring: y>0
				cx_q <= cmd.rot_step ? cx_q - ys : cx_q + ys;
				cy_q <= cmd.rot_step ? cy_q + xs : cy_q - xs;
				cz_q <= cmd.rot_step ? cz_q - tab : cz_q + tab;
			end else begin
				cx_q <= cmd.rot_step ? cx_q + ys : cx_q - ys;
				cy_q <= cmd.rot_step ? cy_q - xs : cy_q + xs;
				cz_q <= cmd.rot_step ? cz_q + tab : cz_q - tab;
			end
		end
		if (cmd.rot_step && stat.step_done) begin
			e_neg_q <= rot_pos;
		end
		if (cmd.fin) begin
			e_q <= e_s;
			if (rnd > 48'sd32767) begin
				steer_angle <= 16'sh7FFF;
			end else if (rnd < -48'sd32768) begin
				steer_angle <= -16'sh8000;
			end else begin
				steer_angle <= rnd[15:0];
			end
			nearest_index <= 6'(best_q);
			if (theta_q > 17'sd32767) begin
				head_err <= 16'sh7FFF;
			end else if (theta_q < -17'sd32768) begin
				head_err <= -16'sh8000;
			end else begin
				head_err <= theta_q[15:0];
			end
		end
	end

	assign cte = e_q[15:0];

	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_cmp |-> cmp_idx_q < n_q)
		else $error("scan past the searched entries");
	a_sq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rot_init |-> sq_bit_q == 34'd0)
		else $error("rotation starts before square root ends");
	a_hd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pick_set |-> $past(cmd.pick_rd))
		else $error("nearest entry not read before use");

endmodule
`default_nettype wire

>>> rtl/core/stanley_lateral_steering.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stanley_lateral_steering
// Path tracking steering controller with a 64-entry path table.
// ---------------------------------------------------------------------------
// A load item (tuser = 0) writes one path entry. A query item scans the
// first points_in_use entries at one entry a cycle from a registered
// table read, then runs a bit-pair square root, a 16-step CORDIC rotation
// for the sign, up to 40 normalize shifts and a 16-step CORDIC vectoring
// for atan2; its result is then held until any previous result has been
// taken. One item is worked on at a time; the result waits in an output
// register.
module stanley_lateral_steering (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire [55:0]  s_tdata,   // point_index, pos_x, pos_y, angle, zero fill
	input  wire         s_tuser,   // req_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata,   // steer_angle, linear_speed, nearest_index,
	                               // cross_track_error, heading_error, zero fill
	input  wire         cfg_we,
	input  wire [1:0]   cfg_index,
	input  wire [15:0]  cfg_data
);

	logic [15:0] gain_q;
	logic signed [15:0] speed_q;
	logic [6:0] count_q;
	sls_pkg::cmd_t cmd;
	sls_pkg::stat_t stat;
	logic idle;
	logic signed [15:0] steer, cte, herr;
	logic [5:0] nidx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= 16'd256;
			speed_q <= 16'sd256;
			count_q <= 7'd51;
		end else if (cfg_we) begin
			case (cfg_index)
				sls_pkg::REG_GAIN:  gain_q  <= cfg_data;
				sls_pkg::REG_SPEED: speed_q <= cfg_data;
				sls_pkg::REG_COUNT: count_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign s_tready = idle;

	sls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (s_tvalid && s_tready),
		.in_query (s_tuser == sls_pkg::REQ_QUERY),
		.out_busy (m_tvalid && !m_tready),
		.stat     (stat),
		.idle     (idle),
		.cmd      (cmd)
	);

	sls_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.point_index   (s_tdata[5:0]),
		.pos_x         (s_tdata[21:6]),
		.pos_y         (s_tdata[37:22]),
		.angle         (s_tdata[53:38]),
		.gain          (gain_q),
		.speed         (speed_q),
		.count         (count_q),
		.steer_angle   (steer),
		.nearest_index (nidx),
		.cte           (cte),
		.head_err      (herr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.res_set) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			m_tdata <= {2'b0, herr, cte, nidx, speed_q, steer};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");

endmodule
`default_nettype wire
